/* hw/rtl/brd_pkg.sv */
package brd_pkg;

  localparam int unsigned Depth     = 64;
  localparam int unsigned IdxW      = $clog2(Depth);
  localparam int unsigned CntW      = 7;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned ModeW     = 2;
  localparam int unsigned InDataW   = 8;
  localparam int unsigned OutDataW  = 16;
  localparam int unsigned OutUserW  = 3;

  localparam logic [ByteW-1:0] EmptyByte = 8'hFF;
  localparam logic [IdxW-1:0]  LastIdx   = IdxW'(Depth - 1);
  localparam logic [CntW-1:0]  FullCnt   = CntW'(Depth);

  typedef enum logic [ModeW-1:0] {
    MODE_PUSH     = 2'd0,
    MODE_POP_HEAD = 2'd1,
    MODE_POP_TAIL = 2'd2
  } mode_e;

endpackage

/* hw/rtl/byte_ring_deque_top.sv */
// The result beat of an accepted input beat is registered and appears in the cycle after it is accepted.
// Throughput: one beat per cycle; the store has one write port and one
// registered read port, and each beat uses at most one of them.
// Back-pressure on the result side stalls the input side only while the
// result register is full and not being drained.
// Reset (asynchronous, active low) empties the store; contents are not cleared.
module byte_ring_deque_top
  import brd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  input  logic [InDataW-1:0]  s_tdata_i,   // [7:0] push_byte
  input  logic [ModeW-1:0]    s_tuser_i,   // [1:0] mode
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output logic [OutDataW-1:0] m_tdata_o,   // [7:0] read_byte, [14:8] fill_count, [15] zero
  output logic [OutUserW-1:0] m_tuser_o    // [0] read_valid, [1] push_dropped, [2] is_empty
);

  logic [ByteW-1:0] mem_q [Depth];

  logic [IdxW-1:0]  head_q, head_d;
  logic [IdxW-1:0]  tail_q, tail_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  logic             out_vld_q;
  logic [ByteW-1:0] rd_data_q;
  logic             rd_vld_q, rd_vld_d;
  logic             drop_q, drop_d;
  logic [CntW-1:0]  fill_q;

  logic             accept;
  logic             wr_en, rd_en;
  logic [IdxW-1:0]  wr_addr, rd_addr;
  logic [IdxW-1:0]  tail_inc, tail_dec, head_inc;
  logic             is_full, is_empty_now;
  mode_e            mode;

  assign s_tready_o = !out_vld_q || m_tready_i;
  assign accept     = s_tvalid_i && s_tready_o;
  assign mode       = mode_e'(s_tuser_i);

  assign is_full      = (cnt_q >= FullCnt);
  assign is_empty_now = (cnt_q == '0);
  assign tail_inc     = (tail_q == LastIdx) ? '0 : tail_q + 1'b1;
  assign tail_dec     = (tail_q == '0) ? LastIdx : tail_q - 1'b1;
  assign head_inc     = (head_q == LastIdx) ? '0 : head_q + 1'b1;

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    cnt_d    = cnt_q;
    rd_vld_d = 1'b0;
    drop_d   = 1'b0;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    wr_addr  = tail_inc;
    rd_addr  = head_q;
    case (mode)
      MODE_PUSH: begin
        if (is_full) begin
          drop_d = 1'b1;
        end else begin
          wr_en  = 1'b1;
          tail_d = tail_inc;
          cnt_d  = cnt_q + 1'b1;
        end
      end
      MODE_POP_HEAD: begin
        if (!is_empty_now) begin
          rd_en    = 1'b1;
          rd_vld_d = 1'b1;
          rd_addr  = head_q;
          head_d   = head_inc;
          cnt_d    = cnt_q - 1'b1;
        end
      end
      MODE_POP_TAIL: begin
        if (!is_empty_now) begin
          rd_en    = 1'b1;
          rd_vld_d = 1'b1;
          rd_addr  = tail_q;
          tail_d   = tail_dec;
          cnt_d    = cnt_q - 1'b1;
        end
      end
      default: begin
        rd_vld_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept && wr_en) begin
      mem_q[wr_addr] <= s_tdata_i;
    end
    if (accept && rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
    if (accept) begin
      fill_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= LastIdx;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
      rd_vld_q  <= 1'b0;
      drop_q    <= 1'b0;
    end else begin
      if (accept) begin
        head_q    <= head_d;
        tail_q    <= tail_d;
        cnt_q     <= cnt_d;
        out_vld_q <= 1'b1;
        rd_vld_q  <= rd_vld_d;
        drop_q    <= drop_d;
      end else if (m_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = {1'b0, fill_q, (rd_vld_q ? rd_data_q : EmptyByte)};
  assign m_tuser_o  = {(fill_q == '0), drop_q, rd_vld_q};

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("held count above depth");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    IdxW'(tail_q - head_q + 1'b1) == cnt_q[IdxW-1:0])
    else $error("head/tail pointers disagree with held count");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && drop_q |-> fill_q == FullCnt)
    else $error("push dropped while store not full");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(drop_q && rd_vld_q))
    else $error("read and drop flagged on one beat");

  a_accept_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_vld_q && fill_q == cnt_q)
    else $error("accepted beat did not reach result register");

endmodule
